// ===== rtl/core/bdm_pkg.sv =====
`default_nettype none
package bdm_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int HGT_W      = $clog2(MAX_HEIGHT) + 1;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 13;
  localparam int RAW_W      = 16;
  localparam int CH_W       = 8;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CFA    = 2'd2;

  localparam logic [1:0] CFA_RGGB = 2'd0;
  localparam logic [1:0] CFA_BGGR = 2'd1;
  localparam logic [1:0] CFA_GRBG = 2'd2;
  localparam logic [1:0] CFA_GBRG = 2'd3;

  localparam logic OP_RAW   = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // one window column, row 0 (top) in the lowest slot
  typedef logic [2:0][RAW_W-1:0] col_t;

  typedef struct packed {
    logic              emit;
    logic              wr;
    logic              oob;
    logic [ADDR_W-1:0] addr;
    logic              first_col;
    logic              last_col;
    logic              top;
    logic              bottom;
    logic              ox_odd;
    logic              oy_odd;
  } pix_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/bdm_position.sv =====
`default_nettype none
module bdm_position
  import bdm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic             op,
  input  wire logic             geom_wr,
  input  wire logic [CNT_W-1:0] width,
  input  wire logic [HGT_W-1:0] height,
  output logic                  active,
  output logic                  pending,
  output pix_ctl_t              ctl
);

  logic [CNT_W-1:0] cx, cx_next;
  logic [ROW_W-1:0] row, row_next;
  logic             pending_next;
  logic [HGT_W-1:0] cy, oy, row_inc;
  logic [CNT_W-1:0] ox, cx_inc;
  logic             cx0;

  assign active  = (op == OP_RAW) || pending;
  assign cy      = pending ? height : HGT_W'(row);
  assign cx0     = (cx == '0);
  assign ox      = cx0 ? width - CNT_W'(1) : cx - CNT_W'(1);
  assign oy      = cx0 ? cy - HGT_W'(2) : cy - HGT_W'(1);
  assign cx_inc  = cx + CNT_W'(1);
  assign row_inc = HGT_W'(row) + HGT_W'(1);

  always_comb begin
    ctl.emit      = cx0 ? (cy >= HGT_W'(2)) : (cy >= HGT_W'(1));
    ctl.wr        = !pending;
    ctl.oob       = cx[ADDR_W];
    ctl.addr      = cx[ADDR_W-1:0];
    ctl.first_col = (ox == '0);
    ctl.last_col  = (ox >= width - CNT_W'(1));
    ctl.top       = (oy == '0);
    ctl.bottom    = (oy >= height - HGT_W'(1));
    ctl.ox_odd    = ox[0];
    ctl.oy_odd    = oy[0];
  end

  always_comb begin
    cx_next      = cx;
    row_next     = row;
    pending_next = pending;
    if (pending) begin
      if (cx >= width) begin
        cx_next      = '0;
        row_next     = '0;
        pending_next = 1'b0;
      end else begin
        cx_next = cx_inc;
      end
    end else if (cx_inc >= width) begin
      cx_next = '0;
      if (row_inc >= height) begin
        row_next     = '0;
        pending_next = 1'b1;
      end else begin
        row_next = row_inc[ROW_W-1:0];
      end
    end else begin
      cx_next = cx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      cx      <= '0;
      row     <= '0;
      pending <= 1'b0;
    end else if (accept && active) begin
      cx      <= cx_next;
      row     <= row_next;
      pending <= pending_next;
    end
  end

  a_pend_row: assert property (@(posedge clk) disable iff (rst) pending |-> row == '0)
    else $error("row count not cleared while flushing");
  a_pend_col: assert property (@(posedge clk) disable iff (rst) pending |-> cx <= width)
    else $error("flush column beyond line end");
  a_fill_col: assert property (@(posedge clk) disable iff (rst) !pending |-> cx < width)
    else $error("column count beyond line end");

endmodule
`default_nettype wire

// ===== rtl/core/bdm_line_buf.sv =====
`default_nettype none
module bdm_line_buf
  import bdm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic              rd_oob,
  input  wire logic              mid_wr,
  input  wire logic [RAW_W-1:0]  mid_data,
  input  wire logic              up_wr,
  input  wire logic [ADDR_W-1:0] up_addr,
  output logic      [RAW_W-1:0]  up,
  output logic      [RAW_W-1:0]  mid
);

  logic [RAW_W-1:0] upper_mem  [MAX_WIDTH];
  logic [RAW_W-1:0] middle_mem [MAX_WIDTH];
  logic [RAW_W-1:0] up_q, mid_q;
  logic             oob_q;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q  <= upper_mem[rd_addr];
      oob_q <= rd_oob;
    end
    // upper line takes the old middle sample of the same column
    if (up_wr) begin
      upper_mem[up_addr] <= mid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mid_q <= middle_mem[rd_addr];
    end
    if (mid_wr) begin
      middle_mem[rd_addr] <= mid_data;
    end
  end

  assign up  = oob_q ? '0 : up_q;
  assign mid = oob_q ? '0 : mid_q;

endmodule
`default_nettype wire

// ===== rtl/core/bdm_rgb.sv =====
`default_nettype none
module bdm_rgb
  import bdm_pkg::*;
(
  input  wire col_t       left,
  input  wire col_t       centre,
  input  wire col_t       right,
  input  wire pix_ctl_t   ctl,
  input  wire logic [1:0] cfa,
  output logic [CH_W-1:0] red,
  output logic [CH_W-1:0] green,
  output logic [CH_W-1:0] blue
);

  col_t             lcol, rcol;
  logic [RAW_W-1:0] c, l, r, u, d, ul, drs;
  logic [RAW_W:0]   sum_rd, sum_lr, sum_ud, sum_lu;
  logic             sx, sy, a, b;

  assign lcol = ctl.first_col ? centre : left;
  assign rcol = ctl.last_col ? centre : right;
  assign c    = centre[1];
  assign l    = lcol[1];
  assign r    = rcol[1];
  assign u    = ctl.top ? centre[1] : centre[0];
  assign d    = ctl.bottom ? centre[1] : centre[2];
  assign ul   = ctl.top ? lcol[1] : lcol[0];
  assign drs  = ctl.bottom ? rcol[1] : rcol[2];

  assign sum_rd = {1'b0, r} + {1'b0, d};
  assign sum_lr = {1'b0, l} + {1'b0, r};
  assign sum_ud = {1'b0, u} + {1'b0, d};
  assign sum_lu = {1'b0, l} + {1'b0, u};

  assign sx = (cfa == CFA_BGGR) || (cfa == CFA_GRBG);
  assign sy = (cfa == CFA_BGGR) || (cfa == CFA_GBRG);
  assign a  = ctl.ox_odd ^ sx;
  assign b  = ctl.oy_odd ^ sy;

  // mean then top byte: bits 16..9 of the sum
  always_comb begin
    unique case ({b, a})
      2'b00: begin
        red   = c[RAW_W-1 -: CH_W];
        green = sum_rd[RAW_W -: CH_W];
        blue  = drs[RAW_W-1 -: CH_W];
      end
      2'b01: begin
        green = c[RAW_W-1 -: CH_W];
        red   = sum_lr[RAW_W -: CH_W];
        blue  = sum_ud[RAW_W -: CH_W];
      end
      2'b10: begin
        green = c[RAW_W-1 -: CH_W];
        red   = sum_ud[RAW_W -: CH_W];
        blue  = sum_lr[RAW_W -: CH_W];
      end
      default: begin
        blue  = c[RAW_W-1 -: CH_W];
        green = sum_lu[RAW_W -: CH_W];
        red   = ul[RAW_W-1 -: CH_W];
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/bayer_demosaic_rgb8.sv =====
// The pixel at (x, y) is computed from the sample one line and one pixel later once that
// beat sits in stage 1, and is then registered in the output register.
// Throughput: one sample per cycle unless the output stalls; line stores are read and
// written once per beat. A frame ends with width_eff+1 drain beats flushing the last row.
// Reset: registers back to 4096 x 3072 RGGB, frame position and window cleared; the line
// stores are not cleared, edge clamping keeps unwritten entries out of every result.
`default_nettype none
module bayer_demosaic_rgb8
  import bdm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // raw_value
  input  wire logic [0:0]  s_tuser,   // opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // red, green, blue
  output logic             m_tlast,   // end_of_line
  output logic      [0:0]  m_tuser,   // end_of_frame
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int XW = (DIM_W > CNT_W) ? DIM_W : CNT_W;

  logic [DIM_W-1:0] image_width, image_height;
  logic [1:0]       cfa_order;
  logic             cfg_wr, geom_wr;
  logic [XW-1:0]    wx;
  logic [DIM_W-1:0] hx;
  logic [CNT_W-1:0] width_eff;
  logic [HGT_W-1:0] height_eff;

  logic             accept, active, pending, out_free, s1_move;
  pix_ctl_t         ctl, s1_ctl;
  logic             s1_valid;
  logic [RAW_W-1:0] s1_bot, up, mid;
  col_t             win_l, win_c, win_r;
  logic [CH_W-1:0]  red, green, blue;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign geom_wr = cfg_wr && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(4096);
      image_height <= DIM_W'(3072);
      cfa_order    <= CFA_RGGB;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        REG_CFA:    cfa_order    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      REG_CFA:    prdata = 32'(cfa_order);
      default:    prdata = '0;
    endcase
  end

  // geometry as used, clamped to the supported range
  always_comb begin
    wx = XW'(image_width);
    if (wx < XW'(2)) wx = XW'(2);
    if (wx > XW'(MAX_WIDTH)) wx = XW'(MAX_WIDTH);
    hx = image_height;
    if (hx < DIM_W'(2)) hx = DIM_W'(2);
    if (hx > DIM_W'(MAX_HEIGHT)) hx = DIM_W'(MAX_HEIGHT);
  end
  assign width_eff  = wx[CNT_W-1:0];
  assign height_eff = HGT_W'(hx);

  // flow control: stage 1 holds back only for a result that cannot leave
  assign out_free = !m_tvalid || m_tready;
  assign s1_move  = s1_valid && (!s1_ctl.emit || out_free);
  assign s_tready = !s1_valid || s1_move;
  assign accept   = s_tvalid && s_tready;

  bdm_position u_position (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .op      (s_tuser[0]),
    .geom_wr (geom_wr),
    .width   (width_eff),
    .height  (height_eff),
    .active  (active),
    .pending (pending),
    .ctl     (ctl)
  );

  bdm_line_buf u_line_buf (
    .clk      (clk),
    .rd_en    (accept && active),
    .rd_addr  (ctl.addr),
    .rd_oob   (ctl.oob),
    .mid_wr   (accept && active && ctl.wr),
    .mid_data (s_tdata),
    .up_wr    (s1_move && s1_ctl.wr),
    .up_addr  (s1_ctl.addr),
    .up       (up),
    .mid      (mid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= accept && active;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active) begin
      s1_ctl <= ctl;
      s1_bot <= pending ? '0 : s_tdata;
    end
  end

  // new column enters on the right; only the two older columns are kept
  assign win_r = {s1_bot, mid, up};

  always_ff @(posedge clk) begin
    if (rst) begin
      win_l <= '0;
      win_c <= '0;
    end else if (s1_move) begin
      win_l <= win_c;
      win_c <= win_r;
    end
  end

  bdm_rgb u_rgb (
    .left   (win_l),
    .centre (win_c),
    .right  (win_r),
    .ctl    (s1_ctl),
    .cfa    (cfa_order),
    .red    (red),
    .green  (green),
    .blue   (blue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_move && s1_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_ctl.emit) begin
      m_tdata    <= {blue, green, red};
      m_tlast    <= s1_ctl.last_col;
      m_tuser[0] <= s1_ctl.last_col && s1_ctl.bottom;
    end
  end

  a_s1_stall: assert property (@(posedge clk) disable iff (rst)
      s1_valid && !s1_move |-> m_tvalid && !m_tready)
    else $error("stage 1 stalled without output back pressure");
  a_emit_out: assert property (@(posedge clk) disable iff (rst)
      s1_move && s1_ctl.emit |=> m_tvalid)
    else $error("computed pixel not presented");
  a_rw_clash: assert property (@(posedge clk) disable iff (rst)
      s1_move && s1_ctl.wr && accept && active |-> s1_ctl.addr != ctl.addr)
    else $error("line store write and read hit the same column");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import bdm_pkg::*;

  localparam int unsigned IDLE_PCT      = 29;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam logic [1:0]  REG_SPARE     = 2'd3;   // no register behind this index

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eol;
    logic       eof;
  } rgb_pix_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // raw_value
  logic [0:0]  s_tuser  = '0;   // opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // red, green, blue
  logic        m_tlast;         // end_of_line
  logic [0:0]  m_tuser;         // end_of_frame
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  bayer_demosaic_rgb8 dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor state
  logic [12:0] width_reg  = 13'd4096;
  logic [12:0] height_reg = 13'd3072;
  logic [1:0]  cfa_reg    = CFA_RGGB;

  bit [15:0]   upper_mem  [MAX_WIDTH];
  bit [15:0]   middle_mem [MAX_WIDTH];
  bit [15:0]   win [3][3];
  int unsigned col_pos  = 0;
  int unsigned row_pos  = 0;
  bit          flushing = 1'b0;

  rgb_pix_t    pending_pixels [$];

  bit          idle_on = 1'b1;
  int unsigned errors  = 0;
  int unsigned samples_taken = 0;
  int unsigned pixels_seen   = 0;
  int unsigned lines_seen    = 0;
  int unsigned frames_seen   = 0;
  int unsigned cycles        = 0;

  function automatic rgb_pix_t interpolate_pixel(input int unsigned ox, oy, input int cc,
                                                 input int unsigned w, h);
    int          lc, rc, ur, dr;
    int unsigned c, l, r, u, d, ul, dg, red, grn, blu;
    bit          sx, sy, a, b;
    rgb_pix_t    p;
    // clamp neighbours at the frame border
    lc = (ox == 0) ? cc : cc - 1;
    rc = (ox >= w - 1) ? cc : cc + 1;
    if (rc > 2) rc = 2;
    ur = (oy == 0) ? 1 : 0;
    dr = (oy >= h - 1) ? 1 : 2;
    c  = win[1][cc];
    l  = win[1][lc];
    r  = win[1][rc];
    u  = win[ur][cc];
    d  = win[dr][cc];
    ul = win[ur][lc];
    dg = win[dr][rc];
    sx = (cfa_reg == CFA_BGGR) || (cfa_reg == CFA_GRBG);
    sy = (cfa_reg == CFA_BGGR) || (cfa_reg == CFA_GBRG);
    a  = ox[0] ^ sx;
    b  = oy[0] ^ sy;
    case ({b, a})
      2'b00: begin   // red site
        red = c; grn = (r + d) >> 1; blu = dg;
      end
      2'b01: begin   // green, red row
        grn = c; red = (l + r) >> 1; blu = (u + d) >> 1;
      end
      2'b10: begin   // green, blue row
        grn = c; red = (u + d) >> 1; blu = (l + r) >> 1;
      end
      default: begin // blue site
        blu = c; grn = (l + u) >> 1; red = ul;
      end
    endcase
    p.red   = red[15:8];
    p.green = grn[15:8];
    p.blue  = blu[15:8];
    p.eol   = (ox >= w - 1);
    p.eof   = (ox >= w - 1) && (oy >= h - 1);
    return p;
  endfunction

  task automatic predict_beat(input logic op, input logic [15:0] val);
    int unsigned w, h, cx, cy, rr;
    logic [15:0] up, mid, bot;
    w = (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < 2) ? 2 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    if (!flushing && op == OP_DRAIN) return;
    samples_taken++;
    cx  = col_pos;
    cy  = flushing ? h : row_pos;
    up  = '0;
    mid = '0;
    if (cx < MAX_WIDTH) begin
      up  = upper_mem[cx];
      mid = middle_mem[cx];
    end
    bot = flushing ? 16'h0000 : val;
    // first column of a row closes the previous row's last pixel before the shift
    if (cx == 0 && cy >= 2) pending_pixels.push_back(interpolate_pixel(w - 1, cy - 2, 2, w, h));
    for (rr = 0; rr < 3; rr++) begin
      win[rr][0] = win[rr][1];
      win[rr][1] = win[rr][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = bot;
    if (cx != 0 && cy >= 1) pending_pixels.push_back(interpolate_pixel(cx - 1, cy - 1, 1, w, h));
    if (!flushing && cx < MAX_WIDTH) begin
      upper_mem[cx]  = mid;
      middle_mem[cx] = val;
    end
    if (flushing) begin
      if (cx >= w) begin
        col_pos  = 0;
        row_pos  = 0;
        flushing = 1'b0;
      end else begin
        col_pos = cx + 1;
      end
    end else begin
      cx++;
      if (cx >= w) begin
        cx = 0;
        row_pos++;
        if (row_pos >= h) begin
          row_pos  = 0;
          flushing = 1'b1;
        end
      end
      col_pos = cx;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) predict_beat(s_tuser[0], s_tdata);
  end

  // ---------------------------------------------------------------- result check
  string chan_name [5] = '{"red", "green", "blue", "end_of_line", "end_of_frame"};

  always @(posedge clk) begin : pixel_check
    rgb_pix_t   want;
    logic [7:0] got_f  [5];
    logic [7:0] want_f [5];
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: pixel with none expected, got rgb %h eol %b eof %b",
                 $time, m_tdata, m_tlast, m_tuser);
      end else begin
        want   = pending_pixels.pop_front();
        got_f  = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                   {7'd0, m_tlast}, {7'd0, m_tuser[0]}};
        want_f = '{want.red, want.green, want.blue, {7'd0, want.eol}, {7'd0, want.eof}};
        for (int i = 0; i < 5; i++) begin
          if (got_f[i] !== want_f[i]) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, chan_name[i], want_f[i], got_f[i]);
          end
        end
        pixels_seen++;
        if (want.eol) lines_seen++;
        if (want.eof) frames_seen++;
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d pixels outstanding", $time, pending_pixels.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(19))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // called just after a rising edge; returns at the edge where the beat is taken
  task automatic send_beat(input logic op, input logic [15:0] val);
    if (idle_on && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= val;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_WIDTH, REG_HEIGHT: begin
        if (idx == REG_WIDTH) width_reg = data[12:0];
        else height_reg = data[12:0];
        col_pos  = 0;
        row_pos  = 0;
        flushing = 1'b0;
      end
      REG_CFA: cfa_reg = data[1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] w, h, cfa);
    settle();
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    apb_write(REG_CFA, cfa);
  endtask

  // w, h are the geometry in effect; stop_at < w*h abandons the frame early
  task automatic stream_frame(input int unsigned w, h, stop_at, noise_pct);
    int unsigned n, k;
    for (n = 0; n < w * h && n < stop_at; n++) begin
      if ($urandom_range(99) < noise_pct) send_beat(OP_DRAIN, rand_sample());
      send_beat(OP_RAW, rand_sample());
    end
    if (n == w * h) begin
      // a raw beat during the flush counts as a drain
      for (k = 0; k <= w; k++)
        send_beat(($urandom_range(99) < 20) ? OP_RAW : OP_DRAIN, rand_sample());
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_defaults_and_stray_drains();
    // out of reset: 4096 wide, nothing comes out before the window fills
    send_beat(OP_DRAIN, 16'hFFFF);
    send_beat(OP_DRAIN, 16'h0000);
    repeat (8) send_beat(OP_RAW, rand_sample());
  endtask

  task automatic test_small_frames();
    configure(32'd1, 32'd0, CFA_RGGB);   // both clamp up to 2
    apb_write(REG_SPARE, 32'hFFFF_FFFF);
    send_beat(OP_RAW, 16'hFFFF);
    send_beat(OP_RAW, 16'h0000);
    send_beat(OP_RAW, 16'hFFFF);
    send_beat(OP_RAW, 16'h8001);
    send_beat(OP_DRAIN, 16'h0000);
    send_beat(OP_RAW, 16'h1234);
    send_beat(OP_DRAIN, 16'hFFFF);
    send_beat(OP_DRAIN, 16'h5555);       // frame done, ignored
    configure(32'd3, 32'd3, CFA_GBRG);
    send_beat(OP_RAW, 16'h0100);
    send_beat(OP_RAW, 16'hFF00);
    send_beat(OP_RAW, 16'h00FF);
    send_beat(OP_RAW, 16'hFFFF);
    send_beat(OP_RAW, 16'h0000);
    send_beat(OP_RAW, 16'h7FFF);
    settle();
    apb_write(REG_CFA, CFA_BGGR);        // mid-frame order change
    send_beat(OP_RAW, 16'hAAAA);
    send_beat(OP_RAW, 16'h5555);
    send_beat(OP_RAW, 16'hFFFE);
    repeat (4) send_beat(OP_DRAIN, 16'h0000);
  endtask

  task automatic test_extreme_geometry();
    configure(32'hFFFF_FFFF, 32'd2, CFA_GRBG);   // width clamps to 4096, left part way
    stream_frame(MAX_WIDTH, 2, 40, 0);
    configure(32'd0, 32'h0000_1FFF, CFA_BGGR);   // 2 wide, height clamps to 4096
    stream_frame(2, MAX_HEIGHT, 60, 0);
    configure(32'd7, 32'd4096, CFA_RGGB);        // abandoned part way
    stream_frame(7, 4096, 30, 0);
  endtask

  task automatic test_random_frames(input int unsigned target);
    int unsigned w, h, stop, start;
    start = samples_taken;
    while (samples_taken - start < target) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(10, 48) : $urandom_range(2, 9);
      h = $urandom_range(2, 6);
      configure(w, h, $urandom_range(3));
      stop = ($urandom_range(9) == 0) ? $urandom_range(1, w * h - 1) : w * h;
      stream_frame(w, h, stop, 5);
      if (stop == w * h && $urandom_range(3) == 0) send_beat(OP_DRAIN, rand_sample());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults_and_stray_drains();
    test_small_frames();
    test_extreme_geometry();
    test_random_frames(230);
    idle_on = 1'b0;
    test_random_frames(60);
    settle();
    $display("Streamed %0d samples and drains; checked %0d pixels over %0d lines, %0d frames,",
             samples_taken, pixels_seen, lines_seen, frames_seen);
    $display("all four colour orders, clamped and extreme geometry, aborted frames.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
